// ----- rtl/pcft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pcft_pkg;

  // Default sizing of the per-CPU tables.
  localparam int ENTRIES_DEF = 16;
  localparam int CPUS_DEF    = 4;

  // Depth of the request queue between the front and the back.
  localparam int QDEPTH = 2;

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int CPU_FW = 2;
  localparam int PID_W  = 22;
  localparam int CNT_W  = 32;
  localparam int TAG_W  = 32;
  localparam int SLOT_W = 4;
  localparam int ST_W   = 3;

  // Request operations.
  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_IGNORED  = 3'd0;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd1;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [ST_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [ST_W-1:0] ST_READ     = 3'd4;
  localparam logic [ST_W-1:0] ST_CLEARED  = 3'd5;

  // Class of a request as decided by the front.
  typedef enum logic [1:0] {
    CLS_IGN,
    CLS_READ,
    CLS_CLEAR,
    CLS_COUNT
  } pcft_cls_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    pcft_cls_t          cls;
    logic [CPU_FW-1:0]  cpu;
    logic [SLOT_W-1:0]  rslot;
    logic [PID_W-1:0]   pid;
    logic [TAG_W-1:0]   tag;
  } pcft_item_t;

  // One table slot.
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CNT_W-1:0] count;
    logic [TAG_W-1:0] tag;
  } pcft_entry_t;

  // One result.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  entry_pid;
    logic [CNT_W-1:0]  entry_count;
    logic [TAG_W-1:0]  entry_tag;
    logic [PID_W-1:0]  evicted_pid;
  } pcft_result_t;

endpackage
`default_nettype wire

// ----- rtl/pcft_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pcft_front import pcft_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int CPUS    = CPUS_DEF
) (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [CPU_FW-1:0] in_cpu,
  input  wire logic [PID_W-1:0]  in_pid,
  input  wire logic [TAG_W-1:0]  in_task_tag,
  input  wire logic [SLOT_W-1:0] in_read_slot,
  input  wire logic              q_full,
  output logic                   q_push,
  output pcft_item_t             q_item
);

  logic cpu_ok;
  logic slot_ok;

  assign cpu_ok   = int'(in_cpu) < CPUS;
  assign slot_ok  = int'(in_read_slot) < ENTRIES;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.cpu   = in_cpu;
    q_item.rslot = in_read_slot;
    q_item.pid   = in_pid;
    q_item.tag   = in_task_tag;
    // Anything out of range, an unknown op or a count without a process is dropped to a
    // plain ignore so that the back never has to check it again.
    priority if (!cpu_ok) begin
      q_item.cls = CLS_IGN;
    end else if (in_op == OP_READ) begin
      q_item.cls = slot_ok ? CLS_READ : CLS_IGN;
    end else if (in_op == OP_CLEAR) begin
      q_item.cls = CLS_CLEAR;
    end else if (in_op == OP_COUNT && in_pid != '0) begin
      q_item.cls = CLS_COUNT;
    end else begin
      q_item.cls = CLS_IGN;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pcft_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pcft_queue import pcft_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire pcft_item_t push_item,
  input  wire logic       pop,
  output logic            full,
  output logic            empty,
  output pcft_item_t      head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W_Q = $clog2(QDEPTH + 1);

  pcft_item_t           buf_r [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0]   fill_r, fill_nxt;

  assign full  = fill_r == CNT_W_Q'(QDEPTH);
  assign empty = fill_r == '0;
  assign head  = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W_Q'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pcft_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pcft_back import pcft_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int CPUS    = CPUS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire pcft_item_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output pcft_result_t     out_res
);

  localparam int TOTAL  = CPUS * ENTRIES;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int ENT_W  = $clog2(ENTRIES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SWAP   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  pcft_item_t        cur_r, cur_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ENT_W-1:0]  idx_r, idx_nxt;
  pcft_entry_t       prev_r, prev_nxt;
  pcft_result_t      res_r, res_nxt;
  logic              out_valid_r;
  pcft_result_t      out_res_r;

  pcft_entry_t       mem [TOTAL];
  logic [TOTAL-1:0]  valid_r;
  pcft_entry_t       rd_data_r;
  logic              rd_vld_r;

  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  pcft_entry_t       wr_data;
  logic              clr;
  logic [ADDR_W-1:0] head_base;
  pcft_entry_t       eff;
  logic [CNT_W-1:0]  upd_cnt;
  logic              emit_go;

  assign head_base = ADDR_W'(q_head.cpu) * ADDR_W'(ENTRIES);
  // A slot never written since reset or the last clear reads as empty.
  assign eff       = rd_vld_r ? rd_data_r : '0;
  assign upd_cnt   = (&eff.count) ? eff.count : eff.count + CNT_W'(1);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    addr_nxt  = addr_r;
    idx_nxt   = idx_r;
    prev_nxt  = prev_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    rd_addr   = addr_r;
    we        = 1'b0;
    wr_addr   = addr_r;
    wr_data   = eff;
    clr       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          res_nxt = '0;
          unique case (q_head.cls)
            CLS_IGN: begin
              state_nxt = S_EMIT;
            end
            CLS_CLEAR: begin
              clr            = 1'b1;
              res_nxt.status = ST_CLEARED;
              state_nxt      = S_EMIT;
            end
            CLS_READ: begin
              rd_addr   = head_base + ADDR_W'(q_head.rslot);
              addr_nxt  = rd_addr;
              state_nxt = S_RDWAIT;
            end
            CLS_COUNT: begin
              rd_addr   = head_base;
              addr_nxt  = head_base;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_nxt.status      = ST_READ;
        res_nxt.slot        = cur_r.rslot;
        res_nxt.entry_pid   = eff.pid;
        res_nxt.entry_count = eff.count;
        res_nxt.entry_tag   = eff.tag;
        state_nxt           = S_EMIT;
      end
      S_SCAN: begin
        rd_addr = addr_r + ADDR_W'(1);
        we      = 1'b1;
        res_nxt.entry_pid = cur_r.pid;
        if (eff.pid == cur_r.pid) begin
          res_nxt.status      = ST_HIT;
          res_nxt.entry_count = upd_cnt;
          res_nxt.entry_tag   = eff.tag;
          if (idx_r != '0 && upd_cnt >= prev_r.count) begin
            // Transpose: the previous slot moves down here, the hit moves up next cycle.
            wr_data      = prev_r;
            res_nxt.slot = SLOT_W'(idx_r - ENT_W'(1));
            state_nxt    = S_SWAP;
          end else begin
            wr_data      = '{pid: cur_r.pid, count: upd_cnt, tag: eff.tag};
            res_nxt.slot = SLOT_W'(idx_r);
            state_nxt    = S_EMIT;
          end
        end else if (idx_r == ENT_W'(ENTRIES - 1) || eff.pid == '0) begin
          wr_data             = '{pid: cur_r.pid, count: CNT_W'(1), tag: cur_r.tag};
          res_nxt.status      = (eff.pid != '0) ? ST_REPLACED : ST_INSERTED;
          res_nxt.slot        = SLOT_W'(idx_r);
          res_nxt.entry_count = CNT_W'(1);
          res_nxt.entry_tag   = cur_r.tag;
          res_nxt.evicted_pid = eff.pid;
          state_nxt           = S_EMIT;
        end else begin
          we       = 1'b0;
          prev_nxt = eff;
          idx_nxt  = idx_r + ENT_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      S_SWAP: begin
        we        = 1'b1;
        wr_addr   = addr_r - ADDR_W'(1);
        wr_data   = '{pid: res_r.entry_pid, count: res_r.entry_count, tag: res_r.entry_tag};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    addr_r <= addr_nxt;
    idx_r  <= idx_nxt;
    prev_r <= prev_nxt;
    res_r  <= res_nxt;
    if (emit_go) begin
      out_res_r <= res_r;
    end
  end

  // Slot store with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (clr) begin
        for (int i = 0; i < ENTRIES; i++) begin
          valid_r[head_base + ADDR_W'(i)] <= 1'b0;
        end
      end
      if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("queue popped outside idle");

  a_swap_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP |-> $past(state_r) == S_SCAN) else $error("swap not after scan");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_SCAN || state_r == S_SWAP)) else $error("stray table write");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT) else $error("result without emit");

  a_no_clear_and_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr && we)) else $error("clear and write together");

endmodule
`default_nettype wire

// ----- rtl/per_cpu_frequency_table_top.sv -----
// An accepted request goes into the queue; the back pops it while idle and moves an ignore or clear
// straight to S_EMIT, a read by way of S_RDWAIT, and loads the result into the output register there.
// A count event scans one slot per cycle in S_SCAN and passes S_SWAP as well when it swaps. The back
// takes one request at a time, held by the scan through the single read port of the slot store and
// by out_ready while a result waits; a two-deep queue lets requests arrive ahead.
// Reset (synchronous, rst_n low) empties every table and the queue and drops any result.
`timescale 1ns / 1ps
`default_nettype none
module per_cpu_frequency_table_top import pcft_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int CPUS    = CPUS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [CPU_FW-1:0] in_cpu,
  input  wire logic [PID_W-1:0]  in_pid,
  input  wire logic [TAG_W-1:0]  in_task_tag,
  input  wire logic [SLOT_W-1:0] in_read_slot,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [PID_W-1:0]       out_entry_pid,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic [TAG_W-1:0]       out_entry_tag,
  output logic [PID_W-1:0]       out_evicted_pid
);

  // The front classifies each request (range checks, unknown ops and counts with a zero pid become
  // ignores), the queue decouples it from the back, and the back walks the chosen CPU's
  // table in the slot store and holds the result in an output register.
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  pcft_item_t   q_item;
  pcft_item_t   q_head;
  pcft_result_t res;

  pcft_front #(
    .ENTRIES (ENTRIES),
    .CPUS    (CPUS)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_cpu       (in_cpu),
    .in_pid       (in_pid),
    .in_task_tag  (in_task_tag),
    .in_read_slot (in_read_slot),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  pcft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  pcft_back #(
    .ENTRIES (ENTRIES),
    .CPUS    (CPUS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // The result register is unpacked onto the individual result ports.
  assign out_status      = res.status;
  assign out_slot        = res.slot;
  assign out_entry_pid   = res.entry_pid;
  assign out_entry_count = res.entry_count;
  assign out_entry_tag   = res.entry_tag;
  assign out_evicted_pid = res.evicted_pid;

endmodule
`default_nettype wire
